>>> rtl/pmq_pkg.sv
package pmq_pkg;

   localparam int NUM_CHANNELS   = 8;
   localparam int NUM_PRIORITIES = 4;
   localparam int CAPACITY       = 16;

   // channels above this number have no enable bit
   localparam int MAX_ENABLED    = 8;

   localparam int CMD_W      = 1;
   localparam int CHAN_W     = 4;
   localparam int PRIO_W     = 2;
   localparam int TYPE_W     = 16;
   localparam int WORD_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int MASK_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CMD_W-1:0] CMD_SEND = 1'b0;
   localparam logic [CMD_W-1:0] CMD_RECV = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MASK  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_ENTRIES = 1'b1;

   localparam logic [COUNT_W-1:0] QUEUE_ENTRIES_RESET = 5'd16;

   typedef struct packed {
      logic [TYPE_W-1:0] mtype;
      logic [WORD_W-1:0] opcode;
      logic [WORD_W-1:0] pointer;
   } msg_type;

endpackage

>>> rtl/pmq_req_if.sv
interface pmq_req_if;
   logic                         valid;
   logic                         ready;
   logic [pmq_pkg::CMD_W-1:0]    cmd;
   logic [pmq_pkg::CHAN_W-1:0]   channel;
   logic [pmq_pkg::PRIO_W-1:0]   priority_req;
   logic [pmq_pkg::TYPE_W-1:0]   msg_type;
   logic [pmq_pkg::WORD_W-1:0]   msg_opcode;
   logic [pmq_pkg::WORD_W-1:0]   msg_pointer;

   modport source (output valid, cmd, channel, priority_req, msg_type, msg_opcode,
                   msg_pointer, input ready);
   modport sink (input valid, cmd, channel, priority_req, msg_type, msg_opcode,
                 msg_pointer, output ready);
endinterface

>>> rtl/pmq_rsp_if.sv
interface pmq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pmq_pkg::STATUS_W-1:0]  status;
   logic [pmq_pkg::TYPE_W-1:0]    out_type;
   logic [pmq_pkg::WORD_W-1:0]    out_opcode;
   logic [pmq_pkg::WORD_W-1:0]    out_pointer;
   logic [pmq_pkg::PRIO_W-1:0]    out_priority;
   logic [pmq_pkg::COUNT_W-1:0]   high_water;

   modport source (output valid, status, out_type, out_opcode, out_pointer, out_priority,
                   high_water, input ready);
   modport sink (input valid, status, out_type, out_opcode, out_pointer, out_priority,
                 high_water, output ready);
endinterface

>>> rtl/pmq_csr_if.sv
interface pmq_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pmq_pkg::CSR_IDX_W-1:0]   index;
   logic [pmq_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/priority_message_queue.sv
// Bank of message channels, each with strict-priority FIFOs.
// req_ch carries one command item: a send (cmd 0) appends the message to the
// FIFO of the given priority of the given channel, a receive (cmd 1) pops the
// oldest message of the highest non-empty priority of that channel.
// rsp_ch returns exactly one item per command: status, the received message
// words and priority (zero unless a receive succeeded) and the channel's
// high-water mark.
// csr_ch writes register 0 (channel enable mask) or 1 (entry limit per
// channel); it is always ready. It must be written only while no command
// is open; the block itself does not enforce this. A command is accepted
// in the idle state; the channel's state row is read from the state memory
// and evaluated in the EVAL state. Sends and rejected commands load their
// result from EVAL; a successful receive passes through FETCH as well, since
// the message memory is read after the state row has picked the slot.
// Reset empties every channel (state rows read as zero until written),
// clears the enable mask and sets the limit to 16. Message memory contents
// are not cleared and need no clearing pass.
// The result sits in an output register; a new command is accepted while it
// waits, and evaluation holds only when a second result would need it.
module priority_message_queue #(
   parameter int NUM_CHANNELS   = pmq_pkg::NUM_CHANNELS,
   parameter int NUM_PRIORITIES = pmq_pkg::NUM_PRIORITIES,
   parameter int CAPACITY       = pmq_pkg::CAPACITY
) (
   input logic         clock,
   input logic         reset,
   pmq_req_if.sink     req_ch,
   pmq_rsp_if.source   rsp_ch,
   pmq_csr_if.sink     csr_ch
);

   localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PI_W    = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
   localparam int HEAD_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W  = $clog2(CAPACITY + 1);
   localparam int CNT_W   = pmq_pkg::COUNT_W;
   localparam int ROW_W   = NUM_PRIORITIES * (HEAD_W + FILL_W) + 2 * CNT_W;
   localparam int DEPTH   = NUM_CHANNELS * NUM_PRIORITIES * CAPACITY;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;

   logic [1:0] state_ff, state_in;

   // configuration
   logic [pmq_pkg::MASK_W-1:0]  mask_ff;
   logic [CNT_W-1:0]            qe_ff;

   // accepted item
   logic [pmq_pkg::CMD_W-1:0]   cmd_ff;
   logic                        ok_ff;
   logic [CH_W-1:0]             ch_idx_ff;
   logic [PI_W-1:0]             prio_ff;
   pmq_pkg::msg_type            msg_ff;
   logic [PI_W-1:0]             pick_ff;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pmq_pkg::STATUS_W-1:0]   status_ff, status_in;
   pmq_pkg::msg_type               out_msg_ff, out_msg_in;
   logic [pmq_pkg::PRIO_W-1:0]     out_prio_ff, out_prio_in;
   logic [CNT_W-1:0]               hw_ff, hw_in;
   logic                           rsp_load;
   logic                           out_free;

   logic                           accept;
   logic                           chan_ok;
   logic [PI_W-1:0]                prio_sat;

   // state row
   logic [ROW_W-1:0]                           row_rd, row_wr;
   logic [NUM_PRIORITIES-1:0][HEAD_W-1:0]      head_cur, head_nxt;
   logic [NUM_PRIORITIES-1:0][FILL_W-1:0]      fill_cur, fill_nxt;
   logic [CNT_W-1:0]                           used_cur, used_nxt, peak_cur, peak_nxt;

   logic [CNT_W-1:0]    limit;
   logic                send_full;
   logic [HEAD_W:0]     slot_sum;
   logic [HEAD_W-1:0]   slot_wr, slot_rd;
   logic                found;
   logic [PI_W-1:0]     pick;
   logic [PI_W-1:0]     fifo_prio;
   logic [HEAD_W-1:0]   fifo_slot;
   logic [ADDR_W-1:0]   msg_addr;
   logic                eval_go;
   logic                row_we, msg_we, msg_re;
   pmq_pkg::msg_type    msg_rd;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         qe_ff   <= pmq_pkg::QUEUE_ENTRIES_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            pmq_pkg::CSR_ENABLE_MASK:   mask_ff <= csr_ch.data;
            pmq_pkg::CSR_QUEUE_ENTRIES: qe_ff   <= csr_ch.data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign chan_ok = (req_ch.channel != '0)
                 && (int'(req_ch.channel) <= NUM_CHANNELS)
                 && (int'(req_ch.channel) <= pmq_pkg::MAX_ENABLED)
                 && mask_ff[3'(req_ch.channel - 4'd1)];

   assign prio_sat = (int'(req_ch.priority_req) >= NUM_PRIORITIES)
                   ? PI_W'(NUM_PRIORITIES - 1) : PI_W'(req_ch.priority_req);

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_ch.cmd;
         ok_ff     <= chan_ok;
         ch_idx_ff <= CH_W'(req_ch.channel - 4'd1);
         prio_ff   <= prio_sat;
         msg_ff    <= '{mtype: req_ch.msg_type, opcode: req_ch.msg_opcode,
                        pointer: req_ch.msg_pointer};
      end
      if (msg_re) begin
         pick_ff <= pick;
      end
   end

   pmq_state_mem #(
      .DEPTH  (NUM_CHANNELS),
      .ADDR_W (CH_W),
      .WIDTH  (ROW_W)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && chan_ok),
      .rd_addr (CH_W'(req_ch.channel - 4'd1)),
      .rd_data (row_rd),
      .wr_en   (row_we),
      .wr_addr (ch_idx_ff),
      .wr_data (row_wr)
   );

   assign {peak_cur, used_cur, fill_cur, head_cur} = row_rd;
   assign row_wr = {peak_nxt, used_nxt, fill_nxt, head_nxt};

   assign limit     = (int'(qe_ff) > CAPACITY) ? CNT_W'(CAPACITY) : qe_ff;
   assign send_full = (used_cur >= limit) || (int'(fill_cur[prio_ff]) >= CAPACITY);

   // tail slot: head plus fill stays below twice the capacity
   assign slot_sum = {1'b0, head_cur[prio_ff]} + (HEAD_W + 1)'(fill_cur[prio_ff]);
   assign slot_wr  = (int'(slot_sum) >= CAPACITY) ? HEAD_W'(int'(slot_sum) - CAPACITY)
                                                  : slot_sum[HEAD_W-1:0];

   // highest non-empty priority wins
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
         if (fill_cur[p] != '0) begin
            found = 1'b1;
            pick  = PI_W'(p);
         end
      end
   end

   assign slot_rd = head_cur[pick];

   always_comb begin
      head_nxt = head_cur;
      fill_nxt = fill_cur;
      used_nxt = used_cur;
      peak_nxt = peak_cur;
      if (cmd_ff == pmq_pkg::CMD_SEND) begin
         fill_nxt[prio_ff] = fill_cur[prio_ff] + FILL_W'(1);
         used_nxt          = used_cur + CNT_W'(1);
         if (peak_cur < used_nxt) begin
            peak_nxt = used_nxt;
         end
      end else begin
         head_nxt[pick] = (int'(slot_rd) == CAPACITY - 1) ? '0 : slot_rd + HEAD_W'(1);
         fill_nxt[pick] = fill_cur[pick] - FILL_W'(1);
         if (used_cur != '0) begin
            used_nxt = used_cur - CNT_W'(1);
         end
      end
   end

   assign fifo_prio = (cmd_ff == pmq_pkg::CMD_SEND) ? prio_ff : pick;
   assign fifo_slot = (cmd_ff == pmq_pkg::CMD_SEND) ? slot_wr : slot_rd;
   assign msg_addr  = ((ADDR_W'(ch_idx_ff) * ADDR_W'(NUM_PRIORITIES) + ADDR_W'(fifo_prio))
                      * ADDR_W'(CAPACITY)) + ADDR_W'(fifo_slot);

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // a receive that finds a message produces its result only after the fetch
   assign eval_go = (ok_ff && (cmd_ff == pmq_pkg::CMD_RECV) && found) ? 1'b1 : out_free;

   assign msg_we = (state_ff == ST_EVAL) && ok_ff && (cmd_ff == pmq_pkg::CMD_SEND)
                && !send_full && out_free;
   assign msg_re = (state_ff == ST_EVAL) && ok_ff && (cmd_ff == pmq_pkg::CMD_RECV) && found;
   assign row_we = msg_we || msg_re;

   pmq_msg_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_msg_mem (
      .clock   (clock),
      .wr_en   (msg_we),
      .rd_en   (msg_re),
      .addr    (msg_addr),
      .wr_data (msg_ff),
      .rd_data (msg_rd)
   );

   always_comb begin
      state_in    = state_ff;
      rsp_load    = 1'b0;
      status_in   = pmq_pkg::STATUS_OK;
      out_msg_in  = '0;
      out_prio_in = '0;
      hw_in       = peak_cur;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_go) begin
               if (!ok_ff) begin
                  rsp_load  = 1'b1;
                  status_in = pmq_pkg::STATUS_INVALID;
                  hw_in     = '0;
                  state_in  = ST_IDLE;
               end else if (cmd_ff == pmq_pkg::CMD_SEND) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
                  if (send_full) begin
                     status_in = pmq_pkg::STATUS_FULL;
                  end else begin
                     hw_in = peak_nxt;
                  end
               end else if (!found) begin
                  rsp_load  = 1'b1;
                  status_in = pmq_pkg::STATUS_EMPTY;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // state row is unchanged until the next accept, so its peak still holds
            if (out_free) begin
               rsp_load    = 1'b1;
               out_msg_in  = msg_rd;
               out_prio_in = pmq_pkg::PRIO_W'(pick_ff);
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff   <= status_in;
         out_msg_ff  <= out_msg_in;
         out_prio_ff <= out_prio_in;
         hw_ff       <= hw_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.out_type     = out_msg_ff.mtype;
   assign rsp_ch.out_opcode   = out_msg_ff.opcode;
   assign rsp_ch.out_pointer  = out_msg_ff.pointer;
   assign rsp_ch.out_priority = out_prio_ff;
   assign rsp_ch.high_water   = hw_ff;

   a_fetch_only_recv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (ok_ff && (cmd_ff == pmq_pkg::CMD_RECV)))
      else $error("message fetch without a successful receive");

   a_fetch_follows_read: assert property (@(posedge clock) disable iff (reset)
      msg_re |=> (state_ff == ST_FETCH))
      else $error("message read not followed by fetch");

   a_invalid_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EVAL) && !ok_ff) |-> !row_we)
      else $error("state row written for an invalid channel");

   a_error_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != pmq_pkg::STATUS_OK))
      |-> ((out_msg_ff == '0) && (out_prio_ff == '0)))
      else $error("rejected item carries message data");

   a_invalid_no_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == pmq_pkg::STATUS_INVALID)) |-> (hw_ff == '0))
      else $error("invalid channel reports a high-water mark");

endmodule

>>> rtl/pmq_state_mem.sv
module pmq_state_mem #(
   parameter int DEPTH  = pmq_pkg::NUM_CHANNELS,
   parameter int ADDR_W = 3,
   parameter int WIDTH  = 46
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] row_vld_ff;
   logic [WIDTH-1:0] rdata_ff;
   logic             rvld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // a row never written reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rvld_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvld_ff <= row_vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rvld_ff ? rdata_ff : '0;

endmodule

>>> rtl/pmq_msg_mem.sv
module pmq_msg_mem #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         addr,
   input  pmq_pkg::msg_type          wr_data,
   output pmq_pkg::msg_type          rd_data
);

   pmq_pkg::msg_type mem [DEPTH];
   pmq_pkg::msg_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int MAX_PRINTED     = 50;

   typedef struct packed {
      logic [pmq_pkg::STATUS_W-1:0] status;
      pmq_pkg::msg_type             msg;
      logic [pmq_pkg::PRIO_W-1:0]   out_priority;
      logic [pmq_pkg::COUNT_W-1:0]  high_water;
   } queue_result_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_style_type;

   class scoreboard_type;
      pmq_pkg::msg_type slots [pmq_pkg::NUM_CHANNELS][pmq_pkg::NUM_PRIORITIES]
                              [pmq_pkg::CAPACITY];
      int                          head [pmq_pkg::NUM_CHANNELS][pmq_pkg::NUM_PRIORITIES];
      int                          fill [pmq_pkg::NUM_CHANNELS][pmq_pkg::NUM_PRIORITIES];
      int                          used [pmq_pkg::NUM_CHANNELS];
      int                          peak [pmq_pkg::NUM_CHANNELS];
      logic [pmq_pkg::MASK_W-1:0]  enable_mask;
      logic [pmq_pkg::COUNT_W-1:0] entry_limit;
      queue_result_type            expected_q [$];
      int                          errors;

      function new();
         for (int c = 0; c < pmq_pkg::NUM_CHANNELS; c++) begin
            used[c] = 0;
            peak[c] = 0;
            for (int p = 0; p < pmq_pkg::NUM_PRIORITIES; p++) begin
               head[c][p] = 0;
               fill[c][p] = 0;
            end
         end
         enable_mask = '0;
         entry_limit = pmq_pkg::QUEUE_ENTRIES_RESET;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string text);
         if (errors < MAX_PRINTED)
            $display("mismatch: %s", text);
         errors++;
      endtask

      function void write_register(logic [pmq_pkg::CSR_IDX_W-1:0] idx,
                                   logic [pmq_pkg::CSR_DATA_W-1:0] data);
         if (idx == pmq_pkg::CSR_ENABLE_MASK)
            enable_mask = data[pmq_pkg::MASK_W-1:0];
         else if (idx == pmq_pkg::CSR_QUEUE_ENTRIES)
            entry_limit = data[pmq_pkg::COUNT_W-1:0];
      endfunction

      function void predict_command(logic [pmq_pkg::CMD_W-1:0] cmd,
                                    logic [pmq_pkg::CHAN_W-1:0] chan,
                                    logic [pmq_pkg::PRIO_W-1:0] prio_req,
                                    pmq_pkg::msg_type msg);
         queue_result_type r;
         int               c, p, limit, slot;
         bit               found;
         r = '0;
         c = int'(chan) - 1;
         // channels past the mask width have no enable bit
         if (chan < 1 || chan > pmq_pkg::NUM_CHANNELS || chan > pmq_pkg::MAX_ENABLED ||
             !enable_mask[c]) begin
            r.status = pmq_pkg::STATUS_INVALID;
         end else if (cmd == pmq_pkg::CMD_SEND) begin
            limit = (entry_limit > pmq_pkg::CAPACITY) ? pmq_pkg::CAPACITY : int'(entry_limit);
            p = (prio_req >= pmq_pkg::NUM_PRIORITIES) ? pmq_pkg::NUM_PRIORITIES - 1
                                                       : int'(prio_req);
            if (used[c] >= limit || fill[c][p] >= pmq_pkg::CAPACITY) begin
               r.status = pmq_pkg::STATUS_FULL;
            end else begin
               slot = (head[c][p] + fill[c][p]) % pmq_pkg::CAPACITY;
               slots[c][p][slot] = msg;
               fill[c][p]++;
               used[c]++;
               if (peak[c] < used[c])
                  peak[c] = used[c];
               r.status = pmq_pkg::STATUS_OK;
            end
            r.high_water = pmq_pkg::COUNT_W'(peak[c]);
         end else begin
            r.status = pmq_pkg::STATUS_EMPTY;
            found = 1'b0;
            for (p = pmq_pkg::NUM_PRIORITIES - 1; p >= 0 && !found; p--) begin
               if (fill[c][p] != 0) begin
                  found = 1'b1;
                  r.status = pmq_pkg::STATUS_OK;
                  r.msg = slots[c][p][head[c][p]];
                  r.out_priority = pmq_pkg::PRIO_W'(p);
                  head[c][p] = (head[c][p] + 1) % pmq_pkg::CAPACITY;
                  fill[c][p]--;
                  if (used[c] > 0)
                     used[c]--;
               end
            end
            r.high_water = pmq_pkg::COUNT_W'(peak[c]);
         end
         expected_q.push_back(r);
      endfunction

      task compare_field(string name, logic [pmq_pkg::WORD_W-1:0] got,
                         logic [pmq_pkg::WORD_W-1:0] want);
         if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_response(queue_result_type got);
         queue_result_type want;
         if (expected_q.size() == 0) begin
            report("result item with no command outstanding");
         end else begin
            want = expected_q.pop_front();
            compare_field("status", pmq_pkg::WORD_W'(got.status),
                          pmq_pkg::WORD_W'(want.status));
            compare_field("out_type", pmq_pkg::WORD_W'(got.msg.mtype),
                          pmq_pkg::WORD_W'(want.msg.mtype));
            compare_field("out_opcode", got.msg.opcode, want.msg.opcode);
            compare_field("out_pointer", got.msg.pointer, want.msg.pointer);
            compare_field("out_priority", pmq_pkg::WORD_W'(got.out_priority),
                          pmq_pkg::WORD_W'(want.out_priority));
            compare_field("high_water", pmq_pkg::WORD_W'(got.high_water),
                          pmq_pkg::WORD_W'(want.high_water));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   pmq_req_if req ();
   pmq_rsp_if rsp ();
   pmq_csr_if csr ();

   priority_message_queue u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   scoreboard_type  sb;
   int              burst_left;
   bit              gaps_on;
   int              hold_off_requests;
   stall_style_type stall_style;
   int              idle_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // accepted items at every rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr.valid && csr.ready)
            sb.write_register(csr.index, csr.data);
         if (req.valid && req.ready)
            sb.predict_command(req.cmd, req.channel, req.priority_req,
                               {req.msg_type, req.msg_opcode, req.msg_pointer});
         if (rsp.valid && rsp.ready)
            sb.check_response({rsp.status, rsp.out_type, rsp.out_opcode, rsp.out_pointer,
                               rsp.out_priority, rsp.high_water});
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin : backpressure
      int stall_tick;
      int served;
      stall_tick = 0;
      served = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall_tick++;
         if (served != hold_off_requests) begin
            served = hold_off_requests;
            rsp.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            case (stall_style)
               STALL_NONE:    rsp.ready <= 1'b1;
               STALL_LIGHT:   rsp.ready <= ($urandom_range(0, 3) != 0);
               STALL_HEAVY:   rsp.ready <= ($urandom_range(0, 3) == 0);
               default:       rsp.ready <= ((stall_tick % 7) < 4);
            endcase
         end
      end
   end

   task automatic issue_command(input logic [pmq_pkg::CMD_W-1:0] cmd,
                                input logic [pmq_pkg::CHAN_W-1:0] chan,
                                input logic [pmq_pkg::PRIO_W-1:0] prio,
                                input pmq_pkg::msg_type msg);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req.valid        <= 1'b1;
      req.cmd          <= cmd;
      req.channel      <= chan;
      req.priority_req <= prio;
      req.msg_type     <= msg.mtype;
      req.msg_opcode   <= msg.opcode;
      req.msg_pointer  <= msg.pointer;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic write_csr(input logic [pmq_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pmq_pkg::CSR_DATA_W-1:0] data);
      drain();
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= data;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [pmq_pkg::MASK_W-1:0]     mask;
      logic [pmq_pkg::CSR_DATA_W-1:0] limit_setting;
      logic [pmq_pkg::CMD_W-1:0]      cmd;
      logic [pmq_pkg::CHAN_W-1:0]     chan;
      int                             focus, send_pct, roll;

      sb = new();
      reset = 1'b1;
      req.valid = 1'b0;
      req.cmd = pmq_pkg::CMD_SEND;
      req.channel = '0;
      req.priority_req = '0;
      req.msg_type = '0;
      req.msg_opcode = '0;
      req.msg_pointer = '0;
      csr.valid = 1'b0;
      csr.index = pmq_pkg::CSR_ENABLE_MASK;
      csr.data = '0;
      burst_left = 0;
      gaps_on = 1'b1;
      hold_off_requests = 0;
      stall_style = STALL_NONE;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every channel disabled out of reset
      issue_command(pmq_pkg::CMD_SEND, 4'd1, 2'd0, '0);
      issue_command(pmq_pkg::CMD_RECV, 4'd0, 2'd0, '0);
      write_csr(pmq_pkg::CSR_ENABLE_MASK, 8'hFF);
      issue_command(pmq_pkg::CMD_SEND, 4'd0, 2'd1, '1);
      issue_command(pmq_pkg::CMD_SEND, 4'd9, 2'd2, '1);
      issue_command(pmq_pkg::CMD_RECV, 4'd15, 2'd3, '0);
      issue_command(pmq_pkg::CMD_RECV, 4'd1, 2'd0, '0);
      // one per priority and a second at priority 3, then strict-priority pops
      issue_command(pmq_pkg::CMD_SEND, 4'd1, 2'd0, '0);
      issue_command(pmq_pkg::CMD_SEND, 4'd1, 2'd1, '1);
      issue_command(pmq_pkg::CMD_SEND, 4'd1, 2'd2,
                    {16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555});
      issue_command(pmq_pkg::CMD_SEND, 4'd1, 2'd3,
                    {16'h5555, 32'h5555_5555, 32'hAAAA_AAAA});
      issue_command(pmq_pkg::CMD_SEND, 4'd1, 2'd3,
                    {16'h1234, 32'h89AB_CDEF, 32'h0123_4567});
      repeat (6) issue_command(pmq_pkg::CMD_RECV, 4'd1, 2'd0, '1);
      issue_command(pmq_pkg::CMD_SEND, 4'd8, 2'd3, '1);
      issue_command(pmq_pkg::CMD_RECV, 4'd8, 2'd0, '0);
      // channel full, then the limit lowered below the fill
      write_csr(pmq_pkg::CSR_QUEUE_ENTRIES, 8'd2);
      repeat (3) issue_command(pmq_pkg::CMD_SEND, 4'd2, 2'd1,
                               {16'hBEEF, 32'hDEAD_0000, 32'h0000_FACE});
      write_csr(pmq_pkg::CSR_QUEUE_ENTRIES, 8'd1);
      issue_command(pmq_pkg::CMD_SEND, 4'd2, 2'd0, '1);
      issue_command(pmq_pkg::CMD_RECV, 4'd2, 2'd0, '0);
      issue_command(pmq_pkg::CMD_SEND, 4'd2, 2'd0, '1);
      issue_command(pmq_pkg::CMD_RECV, 4'd2, 2'd0, '0);
      issue_command(pmq_pkg::CMD_SEND, 4'd2, 2'd2, '1);
      // zero limit, then an out-of-range limit
      write_csr(pmq_pkg::CSR_QUEUE_ENTRIES, 8'd0);
      issue_command(pmq_pkg::CMD_SEND, 4'd3, 2'd0, '1);
      write_csr(pmq_pkg::CSR_QUEUE_ENTRIES, 8'hFF);
      write_csr(pmq_pkg::CSR_ENABLE_MASK, 8'hFE);
      issue_command(pmq_pkg::CMD_SEND, 4'd1, 2'd3, '1);
      issue_command(pmq_pkg::CMD_RECV, 4'd1, 2'd0, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         focus = $urandom_range(1, pmq_pkg::NUM_CHANNELS);
         if (phase == 1)
            focus = 1;
         if (phase == 3)
            focus = pmq_pkg::NUM_CHANNELS;
         case (phase)
            0, 9:    mask = '1;
            1, 3:    mask = pmq_pkg::MASK_W'(1) << (focus - 1);
            default: mask = pmq_pkg::MASK_W'($urandom) | (pmq_pkg::MASK_W'(1) << (focus - 1));
         endcase
         case (phase)
            0:       limit_setting = 8'd16;
            1:       limit_setting = 8'd1;
            2:       limit_setting = 8'hD1;
            3:       limit_setting = 8'd4;
            4:       limit_setting = 8'hFF;
            5:       limit_setting = 8'd2;
            6:       limit_setting = 8'h2F;
            7:       limit_setting = 8'h08;
            8:       limit_setting = 8'd16;
            default: limit_setting = 8'h43;
         endcase
         write_csr(pmq_pkg::CSR_ENABLE_MASK, mask);
         write_csr(pmq_pkg::CSR_QUEUE_ENTRIES, limit_setting);
         stall_style = stall_style_type'(phase % 4);
         gaps_on = (phase % 3 != 1);
         send_pct = (phase % 2 == 0) ? 75 : 35;
         // long receiver hold-off while the sender keeps offering
         if (phase == 2) begin
            gaps_on = 1'b0;
            hold_off_requests++;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
               chan = pmq_pkg::CHAN_W'($urandom_range(0, 15));
            else if (roll < 65)
               chan = pmq_pkg::CHAN_W'(focus);
            else
               do chan = pmq_pkg::CHAN_W'($urandom_range(1, pmq_pkg::NUM_CHANNELS));
               while (!mask[chan - 1]);
            cmd = ($urandom_range(0, 99) < send_pct) ? pmq_pkg::CMD_SEND : pmq_pkg::CMD_RECV;
            issue_command(cmd, chan,
                          pmq_pkg::PRIO_W'($urandom_range(0, pmq_pkg::NUM_PRIORITIES - 1)),
                          {pmq_pkg::TYPE_W'($urandom), pmq_pkg::WORD_W'($urandom),
                           pmq_pkg::WORD_W'($urandom)});
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report("commands left without a result item");
      if (sb.errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
